### src/b64u_pkg.sv
// shared types, constants and character functions for the base64url encoder
`default_nettype none
package b64u_pkg;

  // group job queue depth, must be a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // percent-encoded pad characters
  localparam logic [6:0] PAD_CH0 = 7'h25;  // '%'
  localparam logic [6:0] PAD_CH1 = 7'h33;  // '3'
  localparam logic [6:0] PAD_CH2 = 7'h44;  // 'D'

  // pad phase codes
  localparam logic [1:0] PH_PCT   = 2'd0;
  localparam logic [1:0] PH_THREE = 2'd1;
  localparam logic [1:0] PH_D     = 2'd2;

  // one job: the sextets of a finished group, index of its last character,
  // and how many pads follow
  typedef struct packed {
    logic [3:0][5:0] sext;
    logic [1:0]      last_idx;
    logic [1:0]      npad;
  } job_t;

  // sextet to base64url character
  function automatic logic [6:0] b64u_char(input logic [5:0] s);
    logic [6:0] c;
    priority if (s < 6'd26) begin
      c = 7'h41 + {1'b0, s};
    end else if (s < 6'd52) begin
      c = 7'h47 + {1'b0, s};
    end else if (s < 6'd62) begin
      c = {1'b0, s} - 7'd4;
    end else if (s == 6'd62) begin
      c = 7'h2D;
    end else begin
      c = 7'h5F;
    end
    return c;
  endfunction

  // pad phase to character
  function automatic logic [6:0] pad_char(input logic [1:0] ph);
    logic [6:0] c;
    unique case (ph)
      PH_PCT:   c = PAD_CH0;
      PH_THREE: c = PAD_CH1;
      PH_D:     c = PAD_CH2;
      default:  c = PAD_CH2;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### src/b64u_front.sv
// front end: gathers bytes into groups and turns each finished group into a job
`default_nettype none
module b64u_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              pad_en,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [7:0]       in_byte,
  input  wire              in_end,
  output logic             job_valid,
  input  wire              job_ready,
  output b64u_pkg::job_t   job
);
  import b64u_pkg::*;

  logic [7:0] byte_a_r, byte_a_nxt;
  logic [7:0] byte_b_r, byte_b_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       acc;

  // a byte is taken whenever the queue has room for a possible job
  assign in_ready = job_ready;
  assign acc      = in_valid && job_ready;

  // classify the byte against the group position
  always_comb begin
    job        = '0;
    job_valid  = 1'b0;
    byte_a_nxt = byte_a_r;
    byte_b_nxt = byte_b_r;
    pos_nxt    = pos_r;
    unique case (pos_r)
      2'd1: begin
        job.sext[0] = byte_a_r[7:2];
        job.sext[1] = {byte_a_r[1:0], in_byte[7:4]};
        job.sext[2] = {in_byte[3:0], 2'b00};
        job.last_idx = 2'd2;
        job.npad     = pad_en ? 2'd1 : 2'd0;
        job_valid    = in_valid && in_end;
        if (acc) begin
          byte_b_nxt = in_byte;
          pos_nxt    = in_end ? 2'd0 : 2'd2;
        end
      end
      2'd2: begin
        job.sext[0] = byte_a_r[7:2];
        job.sext[1] = {byte_a_r[1:0], byte_b_r[7:4]};
        job.sext[2] = {byte_b_r[3:0], in_byte[7:6]};
        job.sext[3] = in_byte[5:0];
        job.last_idx = 2'd3;
        job.npad     = 2'd0;
        job_valid    = in_valid;
        if (acc) begin
          pos_nxt = 2'd0;
        end
      end
      default: begin
        // group start; position three never occurs and acts as start
        job.sext[0] = in_byte[7:2];
        job.sext[1] = {in_byte[1:0], 4'b0000};
        job.last_idx = 2'd1;
        job.npad     = pad_en ? 2'd2 : 2'd0;
        job_valid    = in_valid && in_end;
        if (acc) begin
          byte_a_nxt = in_byte;
          pos_nxt    = in_end ? 2'd0 : 2'd1;
        end
      end
    endcase
  end

  // group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // held bytes
  always_ff @(posedge clk) begin
    byte_a_r <= byte_a_nxt;
    byte_b_r <= byte_b_nxt;
  end

endmodule
`default_nettype wire

### src/b64u_fifo.sv
// short job queue between the front end and the character sequencer
`default_nettype none
module b64u_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  b64u_pkg::job_t   push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output b64u_pkg::job_t   pop_data
);
  import b64u_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### src/b64u_back.sv
// back end: walks a job one character per cycle into the output register while the output is not stalled
`default_nettype none
module b64u_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              job_valid,
  output logic             job_ready,
  input  b64u_pkg::job_t   job,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [6:0]       out_char,
  output logic             out_last
);
  import b64u_pkg::*;

  job_t       job_r;
  logic       job_v_r;
  logic [1:0] idx_r;
  logic       in_pad_r;
  logic [1:0] ph_r;
  logic [1:0] padl_r;
  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       out_last_r;

  logic       adv;
  logic       chars_done;
  logic       done;
  logic [6:0] ch;

  assign adv = job_v_r && (!out_valid_r || out_ready);

  // pick the current character and see whether the job ends with it
  always_comb begin
    chars_done = (idx_r == job_r.last_idx);
    if (!in_pad_r) begin
      ch   = b64u_char(job_r.sext[idx_r]);
      done = chars_done && (job_r.npad == 2'd0);
    end else begin
      ch   = pad_char(ph_r);
      done = (ph_r == PH_D) && (padl_r == 2'd1);
    end
  end

  assign job_ready = !job_v_r || (adv && done);

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r  <= 1'b0;
      idx_r    <= 2'd0;
      in_pad_r <= 1'b0;
      ph_r     <= PH_PCT;
      padl_r   <= 2'd0;
    end else if (job_ready && job_valid) begin
      job_v_r  <= 1'b1;
      idx_r    <= 2'd0;
      in_pad_r <= 1'b0;
    end else if (adv && done) begin
      job_v_r <= 1'b0;
    end else if (adv) begin
      if (!in_pad_r) begin
        if (chars_done) begin
          in_pad_r <= 1'b1;
          ph_r     <= PH_PCT;
          padl_r   <= job_r.npad;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end else if (ph_r == PH_D) begin
        ph_r   <= PH_PCT;
        padl_r <= padl_r - 1'b1;
      end else begin
        ph_r <= ph_r + 1'b1;
      end
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      job_r <= job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_char_r <= ch;
      out_last_r <= done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

### src/base64url_stream_encoder_core.sv
// top level of the base64url stream encoder
`default_nettype none
// Streaming base64url encoder. Bytes enter on in_tdata with in_tlast on the
// final byte of a message; characters leave on out_tdata, one per cycle
// while out_tready is high, with out_tlast on the last character caused by
// an input byte. Every third byte gives four characters; a message ending
// on one or two leftover bytes gives two or three characters, each missing
// character followed by "%3D" when pad_enable is set. The front end takes
// one byte every cycle while the four-entry group queue has room; the back
// end emits one character per cycle while out_tready is high, so the output
// port sets the sustained rate. The first character of a group passes the
// job queue, job register and output register after the byte completing it.
// pad_enable is written on the cfg channel, always ready, and resets to 0.
module base64url_stream_encoder_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] in_byte
  input  wire        in_tlast,
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_data
);
  import b64u_pkg::*;

  logic       pad_en_r;
  logic       fj_valid, fj_ready;
  job_t       fj;
  logic       bj_valid, bj_ready;
  job_t       bj;
  logic [6:0] char_w;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      pad_en_r <= cfg_data;
    end
  end

  b64u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pad_en    (pad_en_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  b64u_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  (fj),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   (bj)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job       (bj),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (char_w),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, char_w};

endmodule
`default_nettype wire

### src/b64u_checker.sv
// port-level checks for the base64url encoder and their binding
`default_nettype none
module b64u_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata,
  input wire       out_tlast
);

  // reset leaves no character pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // stalled character holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // only alphabet and pad characters leave
  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata >= 8'h41 && out_tdata <= 8'h5A) ||
                    (out_tdata >= 8'h61 && out_tdata <= 8'h7A) ||
                    (out_tdata >= 8'h30 && out_tdata <= 8'h39) ||
                    out_tdata == 8'h2D || out_tdata == 8'h5F || out_tdata == 8'h25))
    else $error("illegal output character");

  // a pad never ends on its percent sign
  a_pct_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == 8'h25 |-> !out_tlast)
    else $error("run ended on a percent sign");

endmodule

bind base64url_stream_encoder_core b64u_checker u_b64u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

### verif/base64url_stream_encoder_core_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the base64url stream encoder core
module base64url_stream_encoder_core_test;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int FINAL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 400;
  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  localparam logic [23:0] PCT_PAD = "%3D";

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  // one expected character: ascii code and the last-of-byte flag
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic [7:0] in_tdata = 8'h00;  // [7:0] in_byte
  logic       in_tlast = 1'b0;
  logic       out_tready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_data = 1'b0;
  wire        in_tready;
  wire        out_tvalid;
  wire  [7:0] out_tdata;         // [6:0] out_char, [7] zero
  wire        out_tlast;
  wire        cfg_ready;

  // encoder state as the checker sees it
  logic [15:0] held_pair = 16'h0000;
  logic [1:0]  held_count = 2'd0;
  logic        pad_on = 1'b0;
  enc_char_t   char_q[$];

  int       errors = 0;
  int       cycle_count = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_count = 0;
  int       hold_req = 0;
  int       hold_left = 0;
  int       gap_max = 0;
  int       burst_max = 1;
  int       burst_left = 1;

  base64url_stream_encoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // sextet to base64url character
  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    return ALPHABET[8 * (63 - int'(s)) +: 7];
  endfunction

  // advance the encoder state by one byte and queue the characters it causes
  function automatic void encode_byte(input logic [7:0] b, input logic last);
    logic [6:0] chars [0:7];
    logic [7:0] a;
    logic [7:0] m;
    enc_char_t  e;
    int         n;
    int         npad;
    int         p;
    int         i;
    n = 0;
    npad = 0;
    a = held_pair[15:8];
    m = held_pair[7:0];
    if (held_count == 2'd1) begin
      if (last) begin
        chars[0] = sextet_char(a[7:2]);
        chars[1] = sextet_char({a[1:0], b[7:4]});
        chars[2] = sextet_char({b[3:0], 2'b00});
        n = 3;
        npad = 1;
        held_pair = 16'h0000;
        held_count = 2'd0;
      end else begin
        held_pair = {a, b};
        held_count = 2'd2;
      end
    end else if (held_count == 2'd2) begin
      // a full group goes out whether or not the message ends here
      chars[0] = sextet_char(a[7:2]);
      chars[1] = sextet_char({a[1:0], m[7:4]});
      chars[2] = sextet_char({m[3:0], b[7:6]});
      chars[3] = sextet_char(b[5:0]);
      n = 4;
      held_pair = 16'h0000;
      held_count = 2'd0;
    end else begin
      // group start; position three is treated the same way
      if (last) begin
        chars[0] = sextet_char(b[7:2]);
        chars[1] = sextet_char({b[1:0], 4'b0000});
        n = 2;
        npad = 2;
        held_pair = 16'h0000;
        held_count = 2'd0;
      end else begin
        held_pair = {b, 8'h00};
        held_count = 2'd1;
      end
    end
    if (pad_on) begin
      for (p = 0; p < npad; p++) begin
        chars[n] = PCT_PAD[22:16];
        chars[n + 1] = PCT_PAD[14:8];
        chars[n + 2] = PCT_PAD[6:0];
        n += 3;
      end
    end
    for (i = 0; i < n; i++) begin
      e.ch = chars[i];
      e.last = (i == n - 1);
      char_q.push_back(e);
    end
  endfunction

  function automatic void note_error(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endfunction

  // offer one byte, wait for its transaction, then maybe take a gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    encode_byte(b, last);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && gap_max > 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, burst_max);
    end
  endtask

  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // stop offering and let every expected character drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pad(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pad_on = v;
  endtask

  // short messages with extreme bytes, both pad settings, every leftover count
  task automatic test_directed_edges();
    rx_mode = RX_ALWAYS;
    gap_max = 0;
    wait_idle();
    write_pad(1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    write_pad(1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7E, 1'b1);
    wait_idle();
  endtask

  // random messages, mostly short, with a few long ones
  task automatic test_random_traffic(input int items, input logic pad, input rx_mode_t mode,
                                     input int gaps, input int bursts);
    int sent;
    int len;
    wait_idle();
    write_pad(pad);
    rx_mode = mode;
    gap_max = gaps;
    burst_max = bursts;
    burst_left = 1;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
      send_message(len);
      sent += len;
    end
    wait_idle();
  endtask

  // receiver holds off while bytes keep coming, so the input must stall
  task automatic test_output_hold();
    int i;
    wait_idle();
    write_pad(1'b1);
    rx_mode = RX_ALWAYS;
    gap_max = 0;
    hold_req = HOLD_CYCLES;
    for (i = 0; i < 20; i++) send_message($urandom_range(1, 2));
    wait_idle();
  endtask

  // receiver ready pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    rx_count = rx_count + 1;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_tready <= 1'b1;
        RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_tready <= ((rx_count % 7) < 4);
        default:    out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // compare each output transaction with the oldest expected character
  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (char_q.size() == 0) begin
        note_error($sformatf("unexpected character: data %h last %b", out_tdata, out_tlast));
      end else begin
        want = char_q.pop_front();
        if (out_tdata[6:0] !== want.ch || out_tdata[7] !== 1'b0 || out_tlast !== want.last)
          note_error($sformatf("mismatch: expected data %h last %b, got data %h last %b",
                               {1'b0, want.ch}, want.last, out_tdata, out_tlast));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_random_traffic(30, 1'b0, RX_RANDOM, 4, 6);
    test_random_traffic(30, 1'b1, RX_PATTERN, 3, 8);
    test_random_traffic(20, 1'b0, RX_ALWAYS, 0, 1);
    test_random_traffic(30, 1'b1, RX_SPARSE, 6, 4);
    test_output_hold();
    repeat (FINAL_CYCLES) @(posedge clk);
    if (errors == 0 && char_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
src/b64u_pkg.sv
src/b64u_front.sv
src/b64u_fifo.sv
src/b64u_back.sv
src/base64url_stream_encoder_core.sv
src/b64u_checker.sv
verif/base64url_stream_encoder_core_test.sv
